[rtl/core/signed_radix_digit_emitter_defines.svh]
// Assertion macros used by the checker file.
`ifndef SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH
`define SIGNED_RADIX_DIGIT_EMITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRDE_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SRDE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/core/srde_pkg.sv]
package srde_pkg;

    localparam int MAX_RADIX  = 16;
    localparam int VALUE_BITS = 32;

    localparam int CHAR_W      = 8;
    localparam int RADIX_W     = 5;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 2;
    localparam int ALPHA_CHARS = 16;
    localparam int ALPHA_W     = ALPHA_CHARS * CHAR_W;
    localparam int DIGIT_W     = $clog2(MAX_RADIX);

    // Divider: DIV_BITS restoring steps per cycle.
    localparam int DIV_BITS   = 8;
    localparam int DIV_CYCLES = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
    localparam int DVD_W      = DIV_CYCLES * DIV_BITS;
    localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    // Digit stack.
    localparam int IDX_W = $clog2(VALUE_BITS);
    localparam int CNT_W = IDX_W + 1;

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [RADIX_W-1:0]    RADIX_RESET      = 5'd10;
    localparam logic [CFG_DATA_W-1:0] ALPHA_LOW_RESET  = 64'd3978425819141910832;
    localparam logic [CFG_DATA_W-1:0] ALPHA_HIGH_RESET = 64'd14648;

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CTRL_HIGH  = 8'd31;
    localparam logic [CHAR_W-1:0] CHAR_DEL   = 8'd127;

    typedef struct packed {
        logic                  neg;
        logic [VALUE_BITS-1:0] mag;
    } item_t;

    typedef struct packed {
        logic [RADIX_W-1:0] radix;
        logic [ALPHA_W-1:0] alphabet;
    } cfg_t;

endpackage

[rtl/core/signed_radix_digit_emitter.sv]
// A taken request passes the front stage register and the queue before it reaches
// the digit unit; each digit is then divided out, and characters leave one per
// cycle after that while the receiver pops. Throughput is set by the shared divider
// (8 quotient bits per cycle); the back end loads a new request only when idle.
// Reset: radix 10 with alphabet "0123456789", queue and result register empty.
module signed_radix_digit_emitter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   push,
    output logic                                   full,
    input  logic signed [srde_pkg::VALUE_BITS-1:0] value,
    output logic                                   empty,
    input  logic                                   pop,
    output logic [srde_pkg::CHAR_W-1:0]            out_char,
    output logic                                   last,
    input  logic                                   cfg_we,
    input  logic [srde_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [srde_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import srde_pkg::*;

    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;
    item_t q_in;
    item_t q_out;
    cfg_t  cfg;

    srde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_item    (q_in),
        .q_full    (q_full),
        .cfg       (cfg)
    );

    srde_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .item_out (q_out),
        .empty    (q_empty)
    );

    srde_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_item   (q_out),
        .cfg      (cfg),
        .empty    (empty),
        .pop      (pop),
        .out_char (out_char),
        .last     (last)
    );

endmodule

[rtl/core/srde_front.sv]
module srde_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic signed [srde_pkg::VALUE_BITS-1:0] value,
    input  logic                                cfg_we,
    input  logic [srde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [srde_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                q_push,
    output srde_pkg::item_t                     q_item,
    input  logic                                q_full,
    output srde_pkg::cfg_t                      cfg
);
    import srde_pkg::*;

    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [CFG_DATA_W-1:0] alpha_low_reg, alpha_low_next;
    logic [CFG_DATA_W-1:0] alpha_high_reg, alpha_high_next;
    logic                  cfg_ok_reg, cfg_ok_next;
    logic                  stage_valid_reg, stage_valid_next;
    logic [VALUE_BITS-1:0] stage_value_reg;
    logic [ALPHA_W-1:0]    alphabet;
    logic                  advance;
    logic                  accept;

    assign alphabet = {alpha_high_reg, alpha_low_reg};
    assign cfg.radix    = radix_reg;
    assign cfg.alphabet = alphabet;

    always_comb
    begin
        radix_next      = radix_reg;
        alpha_low_next  = alpha_low_reg;
        alpha_high_next = alpha_high_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_RADIX:      radix_next      = cfg_data[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_low_next  = cfg_data;
                REG_ALPHA_HIGH: alpha_high_next = cfg_data;
                default:        ;
            endcase
        end
    end

    // Alphabet check over the used characters; registered, so it is settled
    // before any item that follows a register write reaches the queue.
    always_comb
    begin
        logic [CHAR_W-1:0] ch;
        cfg_ok_next = (radix_reg >= RADIX_W'(2)) && (radix_reg <= RADIX_W'(MAX_RADIX));
        for (int i = 0; i < ALPHA_CHARS; i++)
        begin
            ch = alphabet[i*CHAR_W +: CHAR_W];
            if (RADIX_W'(i) < radix_reg)
            begin
                if (ch == CHAR_PLUS || ch == CHAR_MINUS || ch <= CTRL_HIGH || ch == CHAR_DEL)
                    cfg_ok_next = 1'b0;
            end
            for (int j = i + 1; j < ALPHA_CHARS; j++)
            begin
                if (RADIX_W'(j) < radix_reg && alphabet[j*CHAR_W +: CHAR_W] == ch)
                    cfg_ok_next = 1'b0;
            end
        end
    end

    // A request under a bad radix or alphabet is dropped instead of queued.
    assign advance = !cfg_ok_reg || !q_full;
    assign full    = stage_valid_reg && !advance;
    assign accept  = push && !full;
    assign q_push  = stage_valid_reg && cfg_ok_reg && !q_full;

    assign q_item.neg = stage_value_reg[VALUE_BITS-1];
    assign q_item.mag = stage_value_reg[VALUE_BITS-1] ? (~stage_value_reg + 1'b1)
                                                      : stage_value_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
            stage_valid_next = 1'b1;
        else if (advance)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= RADIX_RESET;
            alpha_low_reg   <= ALPHA_LOW_RESET;
            alpha_high_reg  <= ALPHA_HIGH_RESET;
            cfg_ok_reg      <= 1'b1;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            radix_reg       <= radix_next;
            alpha_low_reg   <= alpha_low_next;
            alpha_high_reg  <= alpha_high_next;
            cfg_ok_reg      <= cfg_ok_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            stage_value_reg <= value;
    end

endmodule

[rtl/core/srde_queue.sv]
module srde_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  srde_pkg::item_t item_in,
    output logic            full,
    input  logic            pop,
    output srde_pkg::item_t item_out,
    output logic            empty
);
    import srde_pkg::*;

    item_t              entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_PTR_W:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign item_out = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= item_in;
    end

endmodule

[rtl/core/srde_back.sv]
module srde_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  srde_pkg::item_t             q_item,
    input  srde_pkg::cfg_t              cfg,
    output logic                        empty,
    input  logic                        pop,
    output logic [srde_pkg::CHAR_W-1:0] out_char,
    output logic                        last
);
    import srde_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [DVD_W-1:0]   dvd_reg, dvd_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               neg_reg, neg_next;
    logic [CNT_W-1:0]   dig_cnt_reg, dig_cnt_next;
    logic [DIGIT_W-1:0] digits [VALUE_BITS];
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    logic [DVD_W-1:0]   div_quo;
    logic [DIGIT_W-1:0] div_rem;
    logic [DIGIT_W:0]   base;
    logic               out_free;
    logic               digit_wr;
    logic [CNT_W-1:0]   dig_cnt_m1;
    logic [DIGIT_W-1:0] cur_digit;

    assign empty    = !out_valid_reg;
    assign out_char = out_char_reg;
    assign last     = out_last_reg;
    assign out_free = !out_valid_reg || pop;
    assign q_pop    = (state_reg == ST_IDLE) && !q_empty;

    // The front only passes requests with radix in range, so it fits here.
    assign base = cfg.radix[DIGIT_W:0];

    // DIV_BITS restoring steps; the partial remainder stays below the radix.
    always_comb
    begin
        logic [DIGIT_W:0] r;
        div_quo = dvd_reg;
        div_rem = rem_reg;
        for (int k = 0; k < DIV_BITS; k++)
        begin
            r       = {div_rem, div_quo[DVD_W-1]};
            div_quo = {div_quo[DVD_W-2:0], 1'b0};
            if (r >= base)
            begin
                r          = r - base;
                div_quo[0] = 1'b1;
            end
            div_rem = r[DIGIT_W-1:0];
        end
    end

    assign dig_cnt_m1 = dig_cnt_reg - 1'b1;
    assign cur_digit  = digits[dig_cnt_m1[IDX_W-1:0]];
    assign digit_wr   = (state_reg == ST_DIV) && (step_reg == STEP_W'(DIV_CYCLES - 1));

    always_comb
    begin
        state_next     = state_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        dig_cnt_next   = dig_cnt_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (pop)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    dvd_next     = DVD_W'(q_item.mag);
                    neg_next     = q_item.neg;
                    rem_next     = '0;
                    step_next    = '0;
                    dig_cnt_next = '0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV:
            begin
                dvd_next  = div_quo;
                rem_next  = div_rem;
                step_next = step_reg + 1'b1;
                if (digit_wr)
                begin
                    // One digit done: keep dividing the quotient until it is zero.
                    dig_cnt_next = dig_cnt_reg + 1'b1;
                    step_next    = '0;
                    rem_next     = '0;
                    if (div_quo == '0)
                        state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // Digits were stacked least significant first; pop them back.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = cfg.alphabet[CHAR_W*cur_digit +: CHAR_W];
                    out_last_next  = (dig_cnt_reg == CNT_W'(1));
                    dig_cnt_next   = dig_cnt_m1;
                    if (dig_cnt_reg == CNT_W'(1))
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            dig_cnt_reg   <= dig_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (digit_wr)
            digits[dig_cnt_reg[IDX_W-1:0]] <= div_rem;
    end

endmodule

[rtl/core/srde_checker.sv]
`include "signed_radix_digit_emitter_defines.svh"

module srde_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input logic [srde_pkg::CHAR_W-1:0] out_char,
    input logic                        last
);
    import srde_pkg::*;

    // A waiting result holds until it is taken.
    `SRDE_ASSERT_NEXT(a_result_held, !empty && !pop, !empty && $stable(out_char) && $stable(last))

    // A minus sign is always followed by at least one digit.
    `SRDE_ASSERT_SAME(a_sign_not_last, !empty && out_char == CHAR_MINUS, !last)

    // Only checked alphabet characters or the sign ever come out.
    `SRDE_ASSERT_SAME(a_char_legal, !empty, out_char > CTRL_HIGH && out_char != CHAR_DEL && out_char != CHAR_PLUS)

    // The input side only fills up because a request was just taken.
    `SRDE_ASSERT_SAME(a_full_cause, $rose(full), $past(push))

endmodule

bind signed_radix_digit_emitter srde_checker u_srde_checker (.*);

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;
    import srde_pkg::*;

    localparam int ITEM_TARGET  = 300;
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD    = 800;
    localparam int LIMIT_CYCLES = 600000;
    localparam int REPORT_MAX   = 10;

    // Index 3 is outside the register map; writes to it must be ignored.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [63:0] HEX_LOW  = 64'h3736353433323130;
    localparam logic [63:0] HEX_HIGH = 64'h6665646362613938;

    // Keeps its own copy of the registers, predicts the characters of each
    // request and checks them in order.
    class text_scoreboard;
        logic [RADIX_W-1:0]    radix      = RADIX_RESET;
        logic [CFG_DATA_W-1:0] alpha_low  = ALPHA_LOW_RESET;
        logic [CFG_DATA_W-1:0] alpha_high = ALPHA_HIGH_RESET;
        logic [CHAR_W-1:0]     expected_char[$];
        logic                  expected_last[$];
        int                    failures = 0;

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_RADIX:      radix = data[RADIX_W-1:0];
                REG_ALPHA_LOW:  alpha_low = data;
                REG_ALPHA_HIGH: alpha_high = data;
                default:        ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] alphabet_char(int unsigned pos);
            if (pos < 8)
                return alpha_low[8*pos +: 8];
            return alpha_high[8*(pos-8) +: 8];
        endfunction

        function bit alphabet_ok();
            logic [CHAR_W-1:0] c;
            if (radix < 2 || radix > MAX_RADIX)
                return 1'b0;
            for (int i = 0; i < radix; i++)
            begin
                c = alphabet_char(i);
                if (c == CHAR_PLUS || c == CHAR_MINUS || c <= CTRL_HIGH || c == CHAR_DEL)
                    return 1'b0;
                for (int j = i + 1; j < radix; j++)
                    if (alphabet_char(j) == c)
                        return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_value(logic signed [VALUE_BITS-1:0] v);
            logic [VALUE_BITS-1:0] mag;
            logic [DIGIT_W-1:0]    digits[VALUE_BITS];
            int                    nd;
            if (!alphabet_ok())
                return;
            mag = v[VALUE_BITS-1] ? ~$unsigned(v) + 1'b1 : $unsigned(v);
            nd = 0;
            do
            begin
                digits[nd] = DIGIT_W'(mag % radix);
                nd++;
                mag = mag / radix;
            end
            while (mag != 0);
            if (v[VALUE_BITS-1])
            begin
                expected_char.push_back(CHAR_MINUS);
                expected_last.push_back(1'b0);
            end
            for (int k = nd - 1; k >= 0; k--)
            begin
                expected_char.push_back(alphabet_char(32'(digits[k])));
                expected_last.push_back(k == 0);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] c, logic l);
            logic [CHAR_W-1:0] want_char;
            logic              want_last;
            if (expected_char.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected character %h last %b at %0t", c, l, $realtime);
                return;
            end
            want_char = expected_char.pop_front();
            want_last = expected_last.pop_front();
            if (c !== want_char || l !== want_last)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch at %0t: out_char exp %h got %h, last exp %b got %b",
                             $realtime, want_char, c, want_last, l);
            end
        endfunction

        function int pending();
            return expected_char.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         push = 1'b0;
    logic                         full;
    logic signed [VALUE_BITS-1:0] value = '0;
    logic                         empty;
    logic                         pop = 1'b0;
    logic [CHAR_W-1:0]            out_char;
    logic                         last;
    logic                         cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    text_scoreboard sb = new();
    int hold_cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int valid_sent = 0;

    signed_radix_digit_emitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .value     (value),
        .empty     (empty),
        .pop       (pop),
        .out_char  (out_char),
        .last      (last),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("** signed_radix_digit_emitter: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_value(value);
            if (pop && !empty)
                sb.check_char(out_char, last);
        end
    end

    // The receiver switches between stall patterns; a long hold-off requested
    // by the stimulus is counted down here.
    initial
    begin : receiver
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    0:       pop <= 1'b1;
                    1:       pop <= 1'($urandom_range(0, 1));
                    2:       pop <= ($urandom_range(0, 5) == 0);
                    default: pop <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    task automatic offer_value(input logic signed [VALUE_BITS-1:0] v);
        while (gap_left > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            gap_left--;
        end
        @(negedge clk);
        push <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (full);
        if (sb.alphabet_ok())
            valid_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    task automatic rest_sender();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0)
            @(posedge clk);
        // Requests under an invalid alphabet leave nothing to wait for.
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        sb.write_reg(index, data);
    endtask

    task automatic apply_config(input logic [RADIX_W-1:0] r,
                                input logic [63:0] lo,
                                input logic [63:0] hi);
        logic [CFG_DATA_W-1:0] radix_word;
        rest_sender();
        wait_drained();
        radix_word = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
        radix_word[RADIX_W-1:0] = r;
        write_reg(REG_RADIX, radix_word);
        write_reg(REG_ALPHA_LOW, lo);
        write_reg(REG_ALPHA_HIGH, hi);
        write_reg(REG_SPARE, {$urandom, $urandom});
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_alphabet(input int r, output logic [63:0] lo, output logic [63:0] hi);
        logic [7:0] chars[16];
        logic [7:0] c;
        bit         clash;
        for (int i = 0; i < 16; i++)
            chars[i] = 8'($urandom);
        for (int i = 0; i < r; i++)
        begin
            do
            begin
                c = 8'($urandom_range(32, 255));
                clash = (c == CHAR_PLUS || c == CHAR_MINUS || c == CHAR_DEL);
                for (int j = 0; j < i; j++)
                    if (chars[j] == c)
                        clash = 1'b1;
            end
            while (clash);
            chars[i] = c;
        end
        for (int i = 0; i < 8; i++)
        begin
            lo[8*i +: 8] = chars[i];
            hi[8*i +: 8] = chars[i+8];
        end
    endtask

    function automatic logic signed [VALUE_BITS-1:0] random_value();
        int small_val;
        small_val = $urandom_range(0, 40);
        case ($urandom_range(0, 7))
            0:       return 32'sh80000000;
            1:       return 32'sh7FFFFFFF;
            2:       return small_val - 20;
            3:       return -$signed($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    initial
    begin : stimulus
        logic signed [VALUE_BITS-1:0] dir_vals[$];
        logic [63:0]                  lo;
        logic [63:0]                  hi;
        logic [RADIX_W-1:0]           r;
        int                           n;
        bit                           hold_done;

        hold_done = 1'b0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Decimal digits straight out of reset.
        dir_vals = '{0, 1, -1, 9, 10, -10, 100, 32'sh7FFFFFFF, 32'sh80000000,
                     -2147483647, 1000000000};
        foreach (dir_vals[i])
            offer_value(dir_vals[i]);

        // Base 2 gives the longest text: 32 digits plus the sign.
        apply_config(5'd2, 64'h3130, 64'h0);
        dir_vals = '{0, -1, 32'sh7FFFFFFF, 32'sh80000000};
        foreach (dir_vals[i])
            offer_value(dir_vals[i]);

        apply_config(5'd16, HEX_LOW, HEX_HIGH);
        dir_vals = '{32'sh7FFFFFFF, 32'sh80000000, 255, -256};
        foreach (dir_vals[i])
            offer_value(dir_vals[i]);

        // Bytes above 127 are legal digits.
        apply_config(5'd16, 64'hF7F6F5F4F3F2F1F0, 64'hFFFEFDFCFBFAF9F8);
        dir_vals = '{-1, 32'sh12345678, 32'sh80000000};
        foreach (dir_vals[i])
            offer_value(dir_vals[i]);

        // Illegal characters in unused positions do not matter.
        apply_config(5'd4, 64'h307F002D33323130, 64'h2B2B2B2B2B2B2B2B);
        dir_vals = '{0, 255, -37};
        foreach (dir_vals[i])
            offer_value(dir_vals[i]);

        // Each of these settings must suppress all output.
        apply_config(5'd0, HEX_LOW, HEX_HIGH);
        offer_value(5);
        offer_value(-5);
        apply_config(5'd1, HEX_LOW, HEX_HIGH);
        offer_value(7);
        offer_value(0);
        apply_config(5'd17, HEX_LOW, HEX_HIGH);
        offer_value(123);
        offer_value(-1);
        apply_config(5'd31, HEX_LOW, HEX_HIGH);
        offer_value(32'sh80000000);
        apply_config(5'd16, 64'h37362B3433323130, HEX_HIGH);
        offer_value(42);
        apply_config(5'd16, HEX_LOW, 64'h2D65646362613938);
        offer_value(-42);
        apply_config(5'd16, 64'h373635343332311F, HEX_HIGH);
        offer_value(1);
        apply_config(5'd16, HEX_LOW, 64'h6665646362610038);
        offer_value(99);
        apply_config(5'd16, 64'h373635347F323130, HEX_HIGH);
        offer_value(-99);
        apply_config(5'd16, HEX_LOW, 64'h6665646162613938);
        offer_value(32'sh7FFFFFFF);

        while (valid_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    r = RADIX_W'($urandom_range(0, 31));
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
                1:
                begin
                    r = $urandom_range(0, 1) ? 5'd2 : 5'd16;
                    random_alphabet(int'(r), lo, hi);
                end
                default:
                begin
                    r = RADIX_W'($urandom_range(2, 16));
                    random_alphabet(int'(r), lo, hi);
                end
            endcase
            apply_config(r, lo, hi);
            if (!sb.alphabet_ok())
            begin
                repeat (3)
                    offer_value(random_value());
            end
            else
            begin
                // Once, hold the output side off long enough for the input to back up.
                if (!hold_done)
                begin
                    hold_cycles = LONG_HOLD;
                    hold_done = 1'b1;
                end
                n = $urandom_range(10, 25);
                repeat (n)
                    offer_value(random_value());
            end
        end

        rest_sender();
        wait_drained();
        if (sb.failures == 0 && sb.pending() == 0)
            $display("** signed_radix_digit_emitter: PASSED **");
        else
            $display("** signed_radix_digit_emitter: FAILED **");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/srde_pkg.sv
rtl/core/srde_front.sv
rtl/core/srde_queue.sv
rtl/core/srde_back.sv
rtl/core/signed_radix_digit_emitter.sv
rtl/core/srde_checker.sv
sim/tb.sv
